/* rtl/core/echoing_line_editor_top_macros.svh */
// Assertion macros shared by the line editor RTL.
// Included by the controller and datapath; depends on nothing else.
`ifndef ECHOING_LINE_EDITOR_TOP_MACROS_SVH
`define ECHOING_LINE_EDITOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ELE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define ELE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ele_pkg.sv */
// Shared types and constants of the echoing line editor.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package ele_pkg;

   // Line store geometry
   localparam int LineDepth = 32;
   localparam int AddrW     = $clog2(LineDepth);
   localparam int CountW    = AddrW;
   localparam int CmpW      = 10;

   // Item field widths
   localparam int ByteW = 8;
   localparam int KindW = 2;
   localparam int LenW  = 5;

   // Register file
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 6;
   localparam logic [CsrIdxW-1:0]  CsrEchoEnable = 2'd0;
   localparam logic [CsrIdxW-1:0]  CsrMaxLine    = 2'd1;
   localparam logic [CsrDataW-1:0] MaxLineReset  = 6'd32;

   // Character codes
   localparam logic [ByteW-1:0] CharBs  = 8'd8;
   localparam logic [ByteW-1:0] CharDel = 8'd127;
   localparam logic [ByteW-1:0] CharCr  = 8'd13;
   localparam logic [ByteW-1:0] CharLf  = 8'd10;
   localparam logic [ByteW-1:0] CharSp  = 8'd32;

   typedef enum logic [KindW-1:0] {
      KIND_ECHO = 2'd0,
      KIND_LINE = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      SEL_ECHO,
      SEL_BS,
      SEL_SP,
      SEL_LF,
      SEL_LINE,
      SEL_END
   } out_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ECHO,
      S_ERASE0,
      S_ERASE1,
      S_ERASE2,
      S_NEWLINE,
      S_FETCH,
      S_LINE,
      S_END
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic        load_char;
      logic        emit;
      out_sel_type sel;
      logic        last;
      logic        store;
      logic        count_dec;
      logic        count_clr;
      logic        idx_clr;
      logic        idx_inc;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic echo;
      logic is_erase;
      logic is_bs;
      logic is_cr;
      logic is_lf;
      logic count_zero;
      logic idx_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/core/ele_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the stored line bytes.
`default_nettype none

module ele_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/ele_datapath.sv */
// Datapath of the line editor: config registers, received byte, count, index,
// line store and the result register. Depends on ele_pkg, ele_ram and the macros.
`default_nettype none
`include "echoing_line_editor_top_macros.svh"

module ele_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ele_pkg::ByteW-1:0]     req_rx_byte,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [ele_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [ele_pkg::CsrDataW-1:0]  csr_data,
   input  wire ele_pkg::cmd_type              cmd,
   output ele_pkg::sts_type                   sts,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ele_pkg::KindW-1:0]          rsp_kind,
   output logic [ele_pkg::ByteW-1:0]          rsp_data,
   output logic [ele_pkg::LenW-1:0]           rsp_line_length,
   output logic                               rsp_last
);
   import ele_pkg::*;

   logic                echo_ff, echo_in;
   logic [CsrDataW-1:0] max_line_ff, max_line_in;
   logic [ByteW-1:0]    char_ff;
   logic [CountW-1:0]   count_ff, count_in;
   logic [AddrW-1:0]    idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [ByteW-1:0]    data_ff, data_in;
   logic [LenW-1:0]     len_ff, len_in;
   logic                last_ff;
   logic [CmpW-1:0]     cap;
   logic                can_store;
   logic                ram_we;
   logic [ByteW-1:0]    ram_rdata;
   logic                out_free;
   logic                emit_take;

   // Register writes
   always_comb begin
      echo_in     = echo_ff;
      max_line_in = max_line_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrEchoEnable: echo_in = csr_data[0];
            CsrMaxLine:    max_line_in = csr_data;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_ff     <= 1'b1;
         max_line_ff <= MaxLineReset;
      end else begin
         echo_ff     <= echo_in;
         max_line_ff <= max_line_in;
      end
   end

   // Hold the received byte
   always_ff @(posedge clock) begin
      if (cmd.load_char) begin
         char_ff <= req_rx_byte;
      end
   end

   // Capacity clamps to the store depth; a store is taken only while count plus one is below it
   assign cap = (CmpW'(max_line_ff) > CmpW'(LineDepth)) ? CmpW'(LineDepth)
                                                        : CmpW'(max_line_ff);
   assign can_store = (CmpW'(count_ff) + CmpW'(1)) < cap;
   assign ram_we    = cmd.store & can_store;

   // Advance count and read index
   always_comb begin
      count_in = count_ff;
      if (cmd.count_clr) begin
         count_in = '0;
      end else if (ram_we) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.count_dec && (count_ff != '0)) begin
         count_in = count_ff - 1'b1;
      end
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   ele_ram #(
      .Width (ByteW),
      .Depth (LineDepth)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff),
      .wr_data (char_ff),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // Result register: loads when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_take = cmd.emit & out_free;

   always_comb begin
      kind_in = KIND_ECHO;
      data_in = '0;
      len_in  = '0;
      case (cmd.sel)
         SEL_ECHO: data_in = char_ff;
         SEL_BS:   data_in = CharBs;
         SEL_SP:   data_in = CharSp;
         SEL_LF:   data_in = CharLf;
         SEL_LINE: begin
            kind_in = KIND_LINE;
            data_in = ram_rdata;
         end
         SEL_END: begin
            kind_in = KIND_END;
            len_in  = LenW'(count_ff);
         end
         default: data_in = '0;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (emit_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_take) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         len_ff  <= len_in;
         last_ff <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_data        = data_ff;
   assign rsp_line_length = len_ff;
   assign rsp_last        = last_ff;

   // Status back to the controller
   always_comb begin
      sts.echo       = echo_ff;
      sts.is_erase   = (char_ff == CharBs) || (char_ff == CharDel);
      sts.is_bs      = (char_ff == CharBs);
      sts.is_cr      = (char_ff == CharCr);
      sts.is_lf      = (char_ff == CharLf);
      sts.count_zero = (count_ff == '0);
      sts.idx_last   = ({1'b0, idx_ff} + 1'b1) == {1'b0, count_ff};
      sts.out_free   = out_free;
   end

   `ELE_ASSERT_NXT(a_end_clears_line, clock, reset, emit_take && (cmd.sel == SEL_END), count_ff == '0, "line end did not clear the count")
   `ELE_ASSERT_IMP(a_line_read_in_range, clock, reset, emit_take && (cmd.sel == SEL_LINE), idx_ff < count_ff, "line byte read beyond the count")
   `ELE_ASSERT_NXT(a_store_counts_up, clock, reset, ram_we && !cmd.count_clr, count_ff == ($past(count_ff) + 1'b1), "store did not advance the count")

endmodule

`default_nettype wire

/* rtl/core/ele_ctrl.sv */
// Controller of the line editor: sequences echo, erase and line drain items.
// Depends on ele_pkg and the assertion macros.
`default_nettype none
`include "echoing_line_editor_top_macros.svh"

module ele_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ele_pkg::sts_type sts,
   output ele_pkg::cmd_type      cmd
);
   import ele_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_char = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.echo) begin
               if (sts.is_erase) begin
                  state_in = sts.count_zero ? S_IDLE : S_ERASE0;
               end else begin
                  state_in = S_ECHO;
               end
            end else if (sts.is_bs) begin
               cmd.count_dec = 1'b1;
               state_in      = S_IDLE;
            end else if (sts.is_cr) begin
               state_in = S_NEWLINE;
            end else if (sts.is_lf) begin
               state_in = S_IDLE;
            end else begin
               cmd.store = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_ECHO: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_ECHO;
            cmd.last = !sts.is_cr;
            if (sts.out_free) begin
               if (sts.is_cr) begin
                  state_in = S_NEWLINE;
               end else begin
                  cmd.store = !sts.is_lf;
                  state_in  = S_IDLE;
               end
            end
         end
         S_ERASE0: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_BS;
            if (sts.out_free) begin
               state_in = S_ERASE1;
            end
         end
         S_ERASE1: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_SP;
            if (sts.out_free) begin
               state_in = S_ERASE2;
            end
         end
         S_ERASE2: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_BS;
            cmd.last = 1'b1;
            if (sts.out_free) begin
               cmd.count_dec = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_NEWLINE: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_LF;
            if (sts.out_free) begin
               cmd.idx_clr = 1'b1;
               state_in    = sts.count_zero ? S_END : S_FETCH;
            end
         end
         // Wait while the store's registered read port presents the byte at the index
         S_FETCH: begin
            state_in = S_LINE;
         end
         S_LINE: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_LINE;
            if (sts.out_free) begin
               cmd.idx_inc = 1'b1;
               state_in    = sts.idx_last ? S_END : S_FETCH;
            end
         end
         S_END: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_END;
            cmd.last = 1'b1;
            if (sts.out_free) begin
               cmd.count_clr = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   `ELE_ASSERT_NXT(a_accept_decodes, clock, reset, req_valid && !req_stall, state_ff == S_DECODE, "accepted item not decoded")
   `ELE_ASSERT_IMP(a_erase_needs_text, clock, reset, (state_ff == S_DECODE) && (state_in == S_ERASE0), !sts.count_zero, "erase echo on an empty line")
   `ELE_ASSERT_NXT(a_last_ends_item, clock, reset, cmd.emit && cmd.last && sts.out_free, state_ff == S_IDLE, "work continued after the final item")

endmodule

`default_nettype wire

/* rtl/core/echoing_line_editor_top.sv */
// Flow: an accepted item is decoded, then its first result is registered from
// the echo, erase or newline state; an item with no result frees the block
// after decode, one item at a time. Erase: 3 results. A carriage return drains
// LF, each stored byte (read via fetch, then line state), then the end marker.
// Reset (synchronous, active high) clears state, count, results, echo on,
// capacity 32; the line store is not cleared and needs no clearing pass.
`default_nettype none

module echoing_line_editor_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ele_pkg::ByteW-1:0]     req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ele_pkg::KindW-1:0]          rsp_kind,
   output logic [ele_pkg::ByteW-1:0]          rsp_data,
   output logic [ele_pkg::LenW-1:0]           rsp_line_length,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ele_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [ele_pkg::CsrDataW-1:0]  csr_data
);
   import ele_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Registers take a write in any cycle
   assign csr_ready = 1'b1;

   ele_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ele_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_rx_byte     (req_rx_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data        (rsp_data),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
